### design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that holds every cycle outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked with reset enabled as well.
`define CHK_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/invc_pkg.sv
// Package: shared types and constants of the inversion counter.
`timescale 1ns / 1ps
package invc_pkg;

   localparam int TOTAL_W = 19;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 19'h7FFFF;

   // control bits that travel with each request down the chain
   typedef struct packed {
      logic valid;
      logic last;
      logic drop;
   } ctrl_type;

endpackage

### design/invc_cell.sv
// One chain cell: holds one stored sample and counts greater values for passing requests.
`timescale 1ns / 1ps
module invc_cell import invc_pkg::*; #(
   parameter int IDX_W    = 10,
   parameter int CELL_IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [31:0]      value_i,
   input  logic [IDX_W-1:0] index_i,
   input  logic [IDX_W-1:0] count_i,
   input  ctrl_type         ctrl_i,
   output logic [31:0]      value_o,
   output logic [IDX_W-1:0] index_o,
   output logic [IDX_W-1:0] count_o,
   output ctrl_type         ctrl_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [31:0]      stored_ff;
   logic [31:0]      value_ff;
   logic [IDX_W-1:0] index_ff;
   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   ctrl_type         ctrl_ff;
   logic             live;
   logic             own_slot;
   logic             greater;

   assign live     = ctrl_i.valid && !ctrl_i.drop;
   assign own_slot = live && (index_i == MY_IDX);
   // only slots written earlier in this sequence take part
   assign greater  = live && (MY_IDX < index_i) && (stored_ff > value_i);
   assign count_in = count_i + IDX_W'(greater);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_i;
      end
      if (advance) begin
         value_ff <= value_i;
         index_ff <= index_i;
         count_ff <= count_in;
         if (own_slot) begin
            stored_ff <= value_i;
         end
      end
   end

   assign value_o = value_ff;
   assign index_o = index_ff;
   assign count_o = count_ff;
   assign ctrl_o  = ctrl_ff;

endmodule

### design/invc_tally.sv
// Chain tail: sums per-request counts and registers the result on the last request.
`timescale 1ns / 1ps
module invc_tally import invc_pkg::*; #(
   parameter int IDX_W = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [IDX_W-1:0]   count_i,
   input  ctrl_type           ctrl_i,
   output logic               rsp_valid,
   output logic [TOTAL_W-1:0] rsp_inversion_total,
   output logic               rsp_overflow_flag
);

   localparam int TOT_W = 2 * IDX_W;
   localparam int SAT_W = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;

   logic [TOT_W-1:0]   total_ff;
   logic [TOT_W-1:0]   total_in;
   logic               drop_ff;
   logic               drop_in;
   logic               valid_ff;
   logic [TOTAL_W-1:0] result_ff;
   logic               flag_ff;
   logic [SAT_W-1:0]   total_ext;
   logic [TOTAL_W-1:0] total_sat;

   assign total_in  = total_ff + TOT_W'(count_i);
   assign drop_in   = drop_ff | ctrl_i.drop;
   assign total_ext = SAT_W'(total_in);
   assign total_sat = (total_ext > SAT_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                       : TOTAL_W'(total_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctrl_i.valid && ctrl_i.last;
         if (ctrl_i.valid) begin
            if (ctrl_i.last) begin
               total_ff <= '0;
               drop_ff  <= 1'b0;
            end else begin
               total_ff <= total_in;
               drop_ff  <= drop_in;
            end
         end
      end
      if (advance) begin
         result_ff <= total_sat;
         flag_ff   <= drop_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_inversion_total = result_ff;
   assign rsp_overflow_flag   = flag_ff;

endmodule

### design/inversion_counter_core.sv
// Inversion counter: systolic chain of MAX_ITEMS compare cells plus a tally stage.
// Throughput: one request per cycle while no stalled response holds the chain, also across sequence boundaries.
// Path: each request passes every cell register of the chain, then the tally register, before rsp_valid.
// A stalled response freezes the whole chain, so req_stall follows it.
// Reset clears control state only; stored samples hold garbage until written.
`timescale 1ns / 1ps
module inversion_counter_core import invc_pkg::*; #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_sample_value,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [TOTAL_W-1:0] rsp_inversion_total,
   output logic               rsp_overflow_flag
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   logic             advance;
   logic [CNT_W-1:0] fill_ff;
   logic             full;

   logic [31:0]      value_s [MAX_ITEMS+1];
   logic [IDX_W-1:0] index_s [MAX_ITEMS+1];
   logic [IDX_W-1:0] count_s [MAX_ITEMS+1];
   ctrl_type         ctrl_s  [MAX_ITEMS+1];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign full      = (fill_ff == CNT_W'(MAX_ITEMS));

   assign value_s[0]      = req_sample_value;
   assign index_s[0]      = fill_ff[IDX_W-1:0];
   assign count_s[0]      = '0;
   assign ctrl_s[0].valid = req_valid;
   assign ctrl_s[0].last  = req_last_item;
   assign ctrl_s[0].drop  = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (req_valid && advance) begin
         if (req_last_item) begin
            fill_ff <= '0;
         end else if (!full) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
      end
   end

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      invc_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .value_i (value_s[g]),
         .index_i (index_s[g]),
         .count_i (count_s[g]),
         .ctrl_i  (ctrl_s[g]),
         .value_o (value_s[g+1]),
         .index_o (index_s[g+1]),
         .count_o (count_s[g+1]),
         .ctrl_o  (ctrl_s[g+1])
      );
   end

   invc_tally #(
      .IDX_W (IDX_W)
   ) u_tally (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .count_i             (count_s[MAX_ITEMS]),
      .ctrl_i              (ctrl_s[MAX_ITEMS]),
      .rsp_valid           (rsp_valid),
      .rsp_inversion_total (rsp_inversion_total),
      .rsp_overflow_flag   (rsp_overflow_flag)
   );

endmodule

### design/invc_checker.sv
// Port-level checker for the inversion counter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module invc_checker import invc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [TOTAL_W-1:0] rsp_inversion_total,
   input logic               rsp_overflow_flag
);

   `CHK_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `CHK_IMPLY(a_req_stall_only_on_rsp_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
   `CHK_IMPLY(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall) && !$past(reset), rsp_valid && $stable(rsp_inversion_total) && $stable(rsp_overflow_flag))
   `CHK_IMPLY(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

endmodule

bind inversion_counter_core invc_checker u_invc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_inversion_total (rsp_inversion_total),
   .rsp_overflow_flag   (rsp_overflow_flag)
);
